@@ sv/pct_pkg.sv @@
package pct_pkg;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_GATE = 1'b1;

  localparam logic REG_WAVEFORM = 1'b0;
  localparam logic REG_VOLUME   = 1'b1;

  localparam int SAMPLE_W = 15;
  localparam int VOLUME_W = 10;
  localparam int MODE_W   = 4;

  localparam logic [MODE_W-1:0] MODE_RESET   = 4'd4;
  localparam logic [VOLUME_W-1:0] VOLUME_RESET = 10'd1000;

  localparam logic [3:0] WF_SET_ONES   = 4'h0;
  localparam logic [3:0] WF_POLY4      = 4'h1;
  localparam logic [3:0] WF_P5_P4      = 4'h2;
  localparam logic [3:0] WF_P5TOP_P4   = 4'h3;
  localparam logic [3:0] WF_DIV2_A     = 4'h4;
  localparam logic [3:0] WF_DIV2_B     = 4'h5;
  localparam logic [3:0] WF_P5_DIV2    = 4'h6;
  localparam logic [3:0] WF_P5TOP_DIV2 = 4'h7;
  localparam logic [3:0] WF_POLY9      = 4'h8;
  localparam logic [3:0] WF_POLY5      = 4'h9;
  localparam logic [3:0] WF_P5_SHIFT   = 4'ha;
  localparam logic [3:0] WF_SET_ONES_B = 4'hb;
  localparam logic [3:0] WF_DIV6_A     = 4'hc;
  localparam logic [3:0] WF_DIV6_B     = 4'hd;
  localparam logic [3:0] WF_P5_DIV6    = 4'he;
  localparam logic [3:0] WF_P5TOP_DIV6 = 4'hf;

  typedef struct packed {
    logic [7:0] p4;
    logic [7:0] p5;
  } poly_t;

  typedef struct packed {
    logic gate_write;
    logic scan_start;
    logic scan_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [7:0] lfsr4(input logic [7:0] r);
    if (r[3:0] == 4'h0) begin
      return 8'd1;
    end
    return {r[6:0], r[3] ^ r[2]};
  endfunction

  function automatic logic [7:0] lfsr5(input logic [7:0] r);
    if (r[4:0] == 5'h00) begin
      return 8'd1;
    end
    return {r[6:0], r[4] ^ r[2]};
  endfunction

  function automatic logic [7:0] div2(input logic [7:0] r);
    return {r[6:0], ~r[0]};
  endfunction

  function automatic logic [7:0] div6(input logic [7:0] r);
    logic bit_in;
    bit_in = (r[2] == 1'b0) && (r[2:0] != 3'b000);
    return {~r[6:0], bit_in};
  endfunction

  function automatic poly_t clock_poly(input poly_t cur, input logic [3:0] mode);
    poly_t nxt;
    nxt = cur;
    case (mode)
      WF_SET_ONES, WF_SET_ONES_B: begin
        nxt.p4 = {cur.p4[6:0], 1'b1};
      end
      WF_POLY4: begin
        nxt.p4 = lfsr4(cur.p4);
      end
      WF_P5_P4: begin
        nxt.p5 = lfsr5(cur.p5);
        if (nxt.p5[3:0] == 4'h8) nxt.p4 = lfsr4(cur.p4);
      end
      WF_P5TOP_P4: begin
        nxt.p5 = lfsr5(cur.p5);
        if (nxt.p5[4]) nxt.p4 = lfsr4(cur.p4);
      end
      WF_DIV2_A, WF_DIV2_B: begin
        nxt.p4 = div2(cur.p4);
      end
      WF_P5_DIV2: begin
        nxt.p5 = lfsr5(cur.p5);
        if (nxt.p5[3:0] == 4'h8) nxt.p4 = div2(cur.p4);
      end
      WF_P5TOP_DIV2: begin
        nxt.p5 = lfsr5(cur.p5);
        if (nxt.p5[4]) nxt.p4 = div2(cur.p4);
      end
      WF_POLY9: begin
        if ((cur.p5[4:0] != 5'h00) || (cur.p4[3:0] != 4'h0)) begin
          nxt.p5 = {cur.p5[6:0], cur.p4[3] ^ cur.p5[4]};
        end else begin
          nxt.p5 = 8'd1;
        end
        nxt.p4 = {cur.p4[6:0], nxt.p5[5]};
      end
      WF_POLY5: begin
        nxt.p5 = lfsr5(cur.p5);
        nxt.p4 = {cur.p4[6:0], nxt.p5[5]};
      end
      WF_P5_SHIFT: begin
        nxt.p5 = lfsr5(cur.p5);
        if (nxt.p5[3:0] == 4'h8) nxt.p4 = {cur.p4[6:0], nxt.p5[4]};
      end
      WF_DIV6_A, WF_DIV6_B: begin
        nxt.p4 = div6(cur.p4);
      end
      WF_P5_DIV6: begin
        nxt.p5 = lfsr5(cur.p5);
        if (nxt.p5[3:0] == 4'h8) nxt.p4 = div6(cur.p4);
      end
      default: begin
        nxt.p5 = lfsr5(cur.p5);
        if (nxt.p5[4]) nxt.p4 = div6(cur.p4);
      end
    endcase
    return nxt;
  endfunction

endpackage

@@ sv/pct_regs.sv @@
module pct_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [pct_pkg::MODE_W-1:0]        waveform_mode,
  output logic [pct_pkg::VOLUME_W-1:0]      note_volume
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_mode <= pct_pkg::MODE_RESET;
      note_volume   <= pct_pkg::VOLUME_RESET;
    end else if (wr) begin
      if (paddr[2] == pct_pkg::REG_WAVEFORM) begin
        waveform_mode <= pwdata[pct_pkg::MODE_W-1:0];
      end else begin
        note_volume <= pwdata[pct_pkg::VOLUME_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == pct_pkg::REG_WAVEFORM) begin
      prdata = {{(32-pct_pkg::MODE_W){1'b0}}, waveform_mode};
    end else begin
      prdata = {{(32-pct_pkg::VOLUME_W){1'b0}}, note_volume};
    end
  end

endmodule

@@ sv/pct_ctrl.sv @@
module pct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_cmd,
  input  pct_pkg::dp_status_t   status,
  output pct_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_cmd == pct_pkg::CMD_GATE) begin
            cmd.gate_write = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.last) begin
          if (status.out_busy) begin
            state_next = ST_HOLD;
          end else begin
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end
      ST_HOLD: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept && (s_cmd == pct_pkg::CMD_TICK) |=> (state == ST_SCAN))
    else $error("tick did not start a scan");

  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_busy)
    else $error("result loaded over a pending one");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> $past(state == ST_SCAN) || $past(state == ST_HOLD))
    else $error("hold entered from outside a scan");

endmodule

@@ sv/pct_datapath.sv @@
module pct_datapath #(
  parameter int CHANNELS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pct_pkg::dp_cmd_t                  cmd,
  output pct_pkg::dp_status_t               status,
  input  logic [4:0]                        channel,
  input  logic                              gate_on,
  input  logic [pct_pkg::MODE_W-1:0]        waveform_mode,
  input  logic [pct_pkg::VOLUME_W-1:0]      note_volume,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pct_pkg::SAMPLE_W-1:0]      sample
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [5:0]          pulse_count [CHANNELS];
  pct_pkg::poly_t      poly        [CHANNELS];
  logic [CHANNELS-1:0] gate;

  logic [IDX_W-1:0]            idx;
  logic [pct_pkg::SAMPLE_W-1:0] acc;
  logic [pct_pkg::SAMPLE_W-1:0] acc_next;

  logic [6:0]     idx_ext;
  logic [6:0]     cnt;
  logic [6:0]     cnt_next;
  logic           clk_en;
  pct_pkg::poly_t poly_cur;
  pct_pkg::poly_t poly_next;
  logic           sounding;

  assign status.last     = (idx == IDX_W'(CHANNELS - 1));
  assign status.out_busy = m_tvalid && !m_tready;

  always_comb begin
    idx_ext   = 7'(idx);
    cnt       = 7'(pulse_count[idx]) + 7'd1;
    cnt_next  = (cnt >= ((idx_ext << 1) + 7'd2)) ? 7'd0 : cnt;
    clk_en    = (cnt_next == 7'd0) || (cnt_next == (idx_ext + 7'd1));
    poly_cur  = poly[idx];
    poly_next = clk_en ? pct_pkg::clock_poly(poly_cur, waveform_mode) : poly_cur;
    sounding  = gate[idx] && poly_next.p4[3];
    acc_next  = acc;
    if (cmd.scan_step && sounding) begin
      acc_next = acc + pct_pkg::SAMPLE_W'(note_volume);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_count[i] <= '0;
        poly[i]        <= '0;
      end
    end else begin
      if (cmd.gate_write && ({1'b0, channel} < 6'(CHANNELS))) begin
        gate[channel[IDX_W-1:0]] <= gate_on;
      end
      if (cmd.scan_step) begin
        pulse_count[idx] <= cnt_next[5:0];
        poly[idx]        <= poly_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx <= '0;
      acc <= '0;
    end else if (cmd.scan_step) begin
      idx <= status.last ? '0 : idx + IDX_W'(1);
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample <= acc_next;
    end
  end

endmodule

@@ sv/poly_counter_tone_bank.sv @@
// channel   direction  handshake         payload
// s_*       in         tvalid/tready     tuser: cmd; tdata: channel, gate_on
// m_*       out        tvalid/tready     tdata: sample
// apb       in         psel/penable      waveform_mode at 0x0, note_volume at 0x4
//
// a gate transaction gives no result
// a tick steps every channel in turn through the shared update unit
// the finished sample waits in the output register; a pending result stalls the
// next scan only at its end
// rst is synchronous and clears all pulse counters, shift registers and gates
module poly_counter_tone_bank #(
  parameter int CHANNELS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // channel[4:0], gate_on[5], zero[7:6]
  input  logic [0:0]  s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // sample[14:0], zero[15]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [pct_pkg::MODE_W-1:0]   waveform_mode;
  logic [pct_pkg::VOLUME_W-1:0] note_volume;
  logic [pct_pkg::SAMPLE_W-1:0] sample;
  pct_pkg::dp_cmd_t             cmd;
  pct_pkg::dp_status_t          status;

  pct_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .waveform_mode (waveform_mode),
    .note_volume   (note_volume)
  );

  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_cmd    (s_tuser[0]),
    .status   (status),
    .cmd      (cmd)
  );

  pct_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .channel       (s_tdata[4:0]),
    .gate_on       (s_tdata[5]),
    .waveform_mode (waveform_mode),
    .note_volume   (note_volume),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .sample        (sample)
  );

  assign m_tdata = {1'b0, sample};

endmodule
